// ===== hw/rtl/hangul_two_set_key_composer_macros.svh =====
// assertion macros for the composer checker
`ifndef HANGUL_TWO_SET_KEY_COMPOSER_MACROS_SVH
`define HANGUL_TWO_SET_KEY_COMPOSER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define HGC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define HGC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hgc_pkg.sv =====
package hgc_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int MAX_RES = 4;

  localparam logic [7:0] NONE_CODE = 8'd128;
  localparam logic [7:0] KEY_BS = 8'd8;
  localparam logic [7:0] KEY_CR = 8'd13;
  localparam logic [7:0] KEY_DEL = 8'd127;

  localparam logic [2:0] ACT_COMMIT = 3'd0;
  localparam logic [2:0] ACT_OPEN = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_PASS = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;
  localparam logic [2:0] ACT_BELL = 3'd5;

  typedef struct packed {
    logic [7:0] pass_char;
    logic [7:0] final_code;
    logic [7:0] medial_code;
    logic [7:0] initial_code;
    logic [2:0] action;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [2:0] count;
  } run_t;

  function automatic res_t mk(logic [2:0] act, logic [7:0] i, logic [7:0] m,
                              logic [7:0] f, logic [7:0] c);
    res_t r;
    r.action = act;
    r.initial_code = i;
    r.medial_code = m;
    r.final_code = f;
    r.pass_char = c;
    return r;
  endfunction

  function automatic res_t act_only(logic [2:0] act);
    return mk(act, NONE_CODE, NONE_CODE, NONE_CODE, 8'd0);
  endfunction

  // zero means no jamo for this key
  function automatic logic [7:0] initial_of(logic [7:0] k);
    logic [7:0] r;
    case (k)
      "r": r = NONE_CODE + 8'd1;
      "R": r = NONE_CODE + 8'd2;
      "s": r = NONE_CODE + 8'd3;
      "e": r = NONE_CODE + 8'd4;
      "E": r = NONE_CODE + 8'd5;
      "f": r = NONE_CODE + 8'd6;
      "a": r = NONE_CODE + 8'd7;
      "q": r = NONE_CODE + 8'd8;
      "Q": r = NONE_CODE + 8'd9;
      "t": r = NONE_CODE + 8'd10;
      "T": r = NONE_CODE + 8'd11;
      "d": r = NONE_CODE + 8'd12;
      "w": r = NONE_CODE + 8'd13;
      "W": r = NONE_CODE + 8'd14;
      "c": r = NONE_CODE + 8'd15;
      "z": r = NONE_CODE + 8'd16;
      "x": r = NONE_CODE + 8'd17;
      "v": r = NONE_CODE + 8'd18;
      "g": r = NONE_CODE + 8'd19;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] vowel_of(logic [7:0] k);
    logic [7:0] r;
    case (k)
      "k": r = NONE_CODE + 8'd1;
      "o": r = NONE_CODE + 8'd2;
      "i": r = NONE_CODE + 8'd3;
      "O": r = NONE_CODE + 8'd4;
      "j": r = NONE_CODE + 8'd5;
      "p": r = NONE_CODE + 8'd6;
      "u": r = NONE_CODE + 8'd7;
      "P": r = NONE_CODE + 8'd8;
      "h": r = NONE_CODE + 8'd9;
      "y": r = NONE_CODE + 8'd13;
      "n": r = NONE_CODE + 8'd14;
      "b": r = NONE_CODE + 8'd18;
      "m": r = NONE_CODE + 8'd19;
      "l": r = NONE_CODE + 8'd21;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] final_of(logic [7:0] k);
    logic [7:0] r;
    case (k)
      "r": r = NONE_CODE + 8'd1;
      "R": r = NONE_CODE + 8'd2;
      "s": r = NONE_CODE + 8'd4;
      "e": r = NONE_CODE + 8'd7;
      "f": r = NONE_CODE + 8'd8;
      "a": r = NONE_CODE + 8'd16;
      "q": r = NONE_CODE + 8'd17;
      "t": r = NONE_CODE + 8'd19;
      "T": r = NONE_CODE + 8'd20;
      "d": r = NONE_CODE + 8'd21;
      "w": r = NONE_CODE + 8'd22;
      "c": r = NONE_CODE + 8'd23;
      "z": r = NONE_CODE + 8'd24;
      "x": r = NONE_CODE + 8'd25;
      "v": r = NONE_CODE + 8'd26;
      "g": r = NONE_CODE + 8'd27;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] join_final(logic [7:0] fin, logic [7:0] k);
    logic [7:0] r;
    r = 8'd0;
    if (fin == NONE_CODE + 8'd1 && k == "t") r = NONE_CODE + 8'd3;
    if (fin == NONE_CODE + 8'd4) begin
      if (k == "w") r = NONE_CODE + 8'd5;
      if (k == "g") r = NONE_CODE + 8'd6;
    end
    if (fin == NONE_CODE + 8'd8) begin
      case (k)
        "r": r = NONE_CODE + 8'd9;
        "a": r = NONE_CODE + 8'd10;
        "q": r = NONE_CODE + 8'd11;
        "t": r = NONE_CODE + 8'd12;
        "x": r = NONE_CODE + 8'd13;
        "v": r = NONE_CODE + 8'd14;
        "g": r = NONE_CODE + 8'd15;
        default: r = 8'd0;
      endcase
    end
    if (fin == NONE_CODE + 8'd17 && k == "t") r = NONE_CODE + 8'd18;
    return r;
  endfunction

  function automatic logic [7:0] join_vowel(logic [7:0] vow, logic [7:0] k);
    logic [7:0] r;
    r = 8'd0;
    if (vow == NONE_CODE + 8'd9) begin
      if (k == "k") r = NONE_CODE + 8'd10;
      if (k == "o") r = NONE_CODE + 8'd11;
      if (k == "l") r = NONE_CODE + 8'd12;
    end
    if (vow == NONE_CODE + 8'd14) begin
      if (k == "j") r = NONE_CODE + 8'd15;
      if (k == "p") r = NONE_CODE + 8'd16;
      if (k == "l") r = NONE_CODE + 8'd17;
    end
    if (vow == NONE_CODE + 8'd19 && k == "l") r = NONE_CODE + 8'd20;
    return r;
  endfunction

endpackage

// ===== hw/rtl/hangul_two_set_key_composer.sv =====
// Two-set Hangul key composer. Each input beat carries one typed key and the line-full
// flag; each output beat is one editor action (commit cell, open cell, write syllable,
// pass char, delete cell or bell), the last action of a key marked by tlast. A key is
// taken into an input register, worked through the composing state and
// turns into a run of zero to four actions held in an output queue. The output port
// drains one action per cycle while m_axis_tready is high; one further key can wait in
// the input register, and it moves into the composing state in the same cycle as the
// last action of the previous one leaves. The toggle key, set through cfg_wr_en and cfg_wr_data,
// resets to 0; the user must write it only while idle, the block itself does not enforce it.
module hangul_two_set_key_composer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // mode_toggle_key
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // key
  input  logic        s_axis_tuser,  // line_full
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // initial_code, medial_code, final_code, pass_char
  output logic [2:0]  m_axis_tuser,  // action
  output logic        m_axis_tlast
);

  logic [7:0] mode_toggle_key;
  logic in_valid;
  logic [7:0] in_key;
  logic in_full;
  logic free;
  logic consume;
  hgc_pkg::run_t run;

  assign consume = in_valid && free;
  assign s_axis_tready = !in_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_toggle_key <= 8'd0;
    end else if (cfg_wr_en) begin
      mode_toggle_key <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_key <= s_axis_tdata;
      in_full <= s_axis_tuser;
    end
  end

  hgc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .load       (consume),
    .key        (in_key),
    .line_full  (in_full),
    .toggle_key (mode_toggle_key),
    .run        (run)
  );

  hgc_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (consume),
    .run           (run),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/hgc_core.sv =====
module hgc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [7:0]          key,
  input  logic                line_full,
  input  logic [7:0]          toggle_key,
  output hgc_pkg::run_t       run
);

  localparam logic [2:0] ST_PLAIN = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_MED = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0] state, state_next;
  logic [7:0] initial_jamo, initial_jamo_next;
  logic [7:0] medial_jamo, medial_jamo_next;
  logic [7:0] final_jamo, final_jamo_next;
  logic [7:0] last_consonant_key, last_consonant_key_next;
  logic [hgc_pkg::SP_W-1:0] stack_pointer, stack_pointer_next;
  logic [7:0] undo_stack [hgc_pkg::STACK_DEPTH];

  logic stk_we;
  logic [hgc_pkg::IDX_W-1:0] stk_wa;
  logic [7:0] stk_wd;

  logic [7:0] ini_k, vow_k, fin_k, jf_k, jv_k, ini_lck, split_ini;
  logic pop_empty, can_push;
  logic [hgc_pkg::SP_W-1:0] sp_dec, sp_inc, pop_sp;
  logic [7:0] pop_val;
  logic plain_key;

  function automatic hgc_pkg::run_t pass_run(logic [2:0] st, logic [7:0] k);
    hgc_pkg::run_t r;
    r = '0;
    if (st > ST_EMPTY && k != hgc_pkg::KEY_DEL) begin
      r.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
      r.res[1] = hgc_pkg::mk(hgc_pkg::ACT_PASS, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE,
                             hgc_pkg::NONE_CODE, k);
      r.count = 3'd2;
    end else begin
      r.res[0] = hgc_pkg::mk(hgc_pkg::ACT_PASS, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE,
                             hgc_pkg::NONE_CODE, k);
      r.count = 3'd1;
    end
    return r;
  endfunction

  function automatic hgc_pkg::run_t new_initial_run(logic [7:0] t);
    hgc_pkg::run_t r;
    r = '0;
    r.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
    r.res[1] = hgc_pkg::act_only(hgc_pkg::ACT_OPEN);
    r.res[2] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, t, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE,
                           8'd0);
    r.count = 3'd3;
    return r;
  endfunction

  assign ini_k = hgc_pkg::initial_of(key);
  assign vow_k = hgc_pkg::vowel_of(key);
  assign fin_k = hgc_pkg::final_of(key);
  assign jf_k = hgc_pkg::join_final(final_jamo, key);
  assign jv_k = hgc_pkg::join_vowel(medial_jamo, key);
  assign ini_lck = hgc_pkg::initial_of(last_consonant_key);
  assign split_ini = (ini_lck != 8'd0) ? ini_lck : hgc_pkg::NONE_CODE;

  assign sp_dec = stack_pointer - hgc_pkg::SP_W'(1);
  assign sp_inc = stack_pointer + hgc_pkg::SP_W'(1);
  assign pop_empty = (stack_pointer == '0) ||
                     (stack_pointer > hgc_pkg::SP_W'(hgc_pkg::STACK_DEPTH));
  assign can_push = stack_pointer < hgc_pkg::SP_W'(hgc_pkg::STACK_DEPTH);
  assign pop_val = pop_empty ? hgc_pkg::NONE_CODE : undo_stack[sp_dec[hgc_pkg::IDX_W-1:0]];
  assign pop_sp = pop_empty ? '0 : sp_dec;

  assign plain_key = line_full && key != hgc_pkg::KEY_BS && key != hgc_pkg::KEY_CR &&
                     key != hgc_pkg::KEY_DEL;

  always_comb begin
    state_next = state;
    initial_jamo_next = initial_jamo;
    medial_jamo_next = medial_jamo;
    final_jamo_next = final_jamo;
    last_consonant_key_next = last_consonant_key;
    stack_pointer_next = stack_pointer;
    stk_we = 1'b0;
    stk_wa = stack_pointer[hgc_pkg::IDX_W-1:0];
    stk_wd = hgc_pkg::NONE_CODE;
    run = '0;
    if (key == toggle_key) begin
      if (state > ST_EMPTY) begin
        run.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
        run.count = 3'd1;
      end
      state_next = (state != ST_PLAIN) ? ST_PLAIN : ST_EMPTY;
    end else if (plain_key) begin
      run.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_BELL);
      run.count = 3'd1;
    end else begin
      unique case (state)
        ST_PLAIN: begin
          run = pass_run(ST_PLAIN, key);
        end
        ST_EMPTY: begin
          stack_pointer_next = '0;
          if (ini_k != 8'd0) begin
            run.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_OPEN);
            run.res[1] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, ini_k, hgc_pkg::NONE_CODE,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.count = 3'd2;
            initial_jamo_next = ini_k;
            state_next = ST_INIT;
          end else if (vow_k != 8'd0) begin
            run.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_OPEN);
            run.res[1] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, hgc_pkg::NONE_CODE, vow_k,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.res[2] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
            run.count = 3'd3;
          end else begin
            run = pass_run(state, key);
          end
        end
        ST_INIT: begin
          if (vow_k != 8'd0) begin
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, vow_k,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.count = 3'd1;
            if (can_push) begin
              stk_we = 1'b1;
              stk_wd = hgc_pkg::NONE_CODE;
              stack_pointer_next = sp_inc;
            end
            medial_jamo_next = vow_k;
            state_next = ST_MED;
          end else if (ini_k != 8'd0) begin
            run = new_initial_run(ini_k);
            initial_jamo_next = ini_k;
            stack_pointer_next = '0;
            state_next = ST_INIT;
          end else if (key == hgc_pkg::KEY_BS) begin
            run.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_DELETE);
            run.count = 3'd1;
            state_next = ST_EMPTY;
          end else begin
            run = pass_run(state, key);
            state_next = ST_EMPTY;
          end
        end
        ST_MED: begin
          if (fin_k != 8'd0) begin
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, medial_jamo, fin_k,
                                     8'd0);
            run.count = 3'd1;
            if (can_push) begin
              stk_we = 1'b1;
              stk_wd = hgc_pkg::NONE_CODE;
              stack_pointer_next = sp_inc;
            end
            final_jamo_next = fin_k;
            last_consonant_key_next = key;
            state_next = ST_FIN;
          end else if (jv_k != 8'd0) begin
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, jv_k,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.count = 3'd1;
            if (can_push) begin
              stk_we = 1'b1;
              stk_wd = medial_jamo;
              stack_pointer_next = sp_inc;
            end
            medial_jamo_next = jv_k;
          end else if (ini_k != 8'd0) begin
            run = new_initial_run(ini_k);
            initial_jamo_next = ini_k;
            stack_pointer_next = '0;
            state_next = ST_INIT;
          end else if (vow_k != 8'd0) begin
            run.res[0] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
            run.res[1] = hgc_pkg::act_only(hgc_pkg::ACT_OPEN);
            run.res[2] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, hgc_pkg::NONE_CODE, vow_k,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.res[3] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
            run.count = 3'd4;
            state_next = ST_EMPTY;
          end else if (key == hgc_pkg::KEY_BS) begin
            medial_jamo_next = pop_val;
            stack_pointer_next = pop_sp;
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, pop_val,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.count = 3'd1;
            if (pop_val == hgc_pkg::NONE_CODE) state_next = ST_INIT;
          end else begin
            run = pass_run(state, key);
            state_next = ST_EMPTY;
          end
        end
        ST_FIN: begin
          if (jf_k != 8'd0) begin
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, medial_jamo, jf_k,
                                     8'd0);
            run.count = 3'd1;
            if (can_push) begin
              stk_we = 1'b1;
              stk_wd = final_jamo;
              stack_pointer_next = sp_inc;
            end
            final_jamo_next = jf_k;
            last_consonant_key_next = key;
          end else if (vow_k != 8'd0) begin
            // the final moves over to open the next syllable
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, medial_jamo, pop_val,
                                     8'd0);
            run.res[1] = hgc_pkg::act_only(hgc_pkg::ACT_COMMIT);
            run.res[2] = hgc_pkg::act_only(hgc_pkg::ACT_OPEN);
            run.res[3] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, split_ini, vow_k,
                                     hgc_pkg::NONE_CODE, 8'd0);
            run.count = 3'd4;
            medial_jamo_next = vow_k;
            initial_jamo_next = split_ini;
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = hgc_pkg::NONE_CODE;
            stack_pointer_next = hgc_pkg::SP_W'(1);
            state_next = ST_MED;
          end else if (ini_k != 8'd0) begin
            run = new_initial_run(ini_k);
            initial_jamo_next = ini_k;
            stack_pointer_next = '0;
            state_next = ST_INIT;
          end else if (key == hgc_pkg::KEY_BS) begin
            final_jamo_next = pop_val;
            stack_pointer_next = pop_sp;
            run.res[0] = hgc_pkg::mk(hgc_pkg::ACT_WRITE, initial_jamo, medial_jamo, pop_val,
                                     8'd0);
            run.count = 3'd1;
            if (pop_val == hgc_pkg::NONE_CODE) state_next = ST_MED;
          end else begin
            run = pass_run(state, key);
            state_next = ST_EMPTY;
          end
        end
        default: begin
          run = pass_run(ST_PLAIN, key);
          state_next = ST_PLAIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PLAIN;
      initial_jamo <= hgc_pkg::NONE_CODE;
      medial_jamo <= hgc_pkg::NONE_CODE;
      final_jamo <= hgc_pkg::NONE_CODE;
      last_consonant_key <= 8'd0;
      stack_pointer <= '0;
    end else if (load) begin
      state <= state_next;
      initial_jamo <= initial_jamo_next;
      medial_jamo <= medial_jamo_next;
      final_jamo <= final_jamo_next;
      last_consonant_key <= last_consonant_key_next;
      stack_pointer <= stack_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && stk_we) begin
      undo_stack[stk_wa] <= stk_wd;
    end
  end

endmodule

// ===== hw/rtl/hgc_out.sv =====
module hgc_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  hgc_pkg::run_t run,
  output logic          free,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast
);

  logic [2:0] left;
  hgc_pkg::res_t [hgc_pkg::MAX_RES-1:0] queue;
  logic take;

  assign take = m_axis_tvalid && m_axis_tready;
  assign free = (left == 3'd0) || (left == 3'd1 && m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
    end else if (load) begin
      left <= run.count;
    end else if (take) begin
      left <= left - 3'd1;
    end
  end

  // head of the run always sits in entry zero
  always_ff @(posedge clk) begin
    if (load) begin
      queue <= run.res;
    end else if (take) begin
      for (int i = 0; i < hgc_pkg::MAX_RES - 1; i++) begin
        queue[i] <= queue[i+1];
      end
    end
  end

  assign m_axis_tvalid = left != 3'd0;
  assign m_axis_tlast = left == 3'd1;
  assign m_axis_tuser = queue[0].action;
  assign m_axis_tdata = {queue[0].pass_char, queue[0].final_code, queue[0].medial_code,
                         queue[0].initial_code};

endmodule

// ===== hw/rtl/hgc_checker.sv =====
`include "hangul_two_set_key_composer_macros.svh"

module hgc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [7:0]  cfg_wr_data,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled beat holds
  `HGC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed while stalled")

  // a bell is the whole answer to its key
  `HGC_ASSERT_NOW(a_bell_last, m_axis_tvalid && m_axis_tuser == hgc_pkg::ACT_BELL, m_axis_tlast, "bell not last")

  // opening a cell is always followed by a write
  `HGC_ASSERT_NOW(a_open_not_last, m_axis_tvalid && m_axis_tuser == hgc_pkg::ACT_OPEN, !m_axis_tlast, "open cell ends a run")

  // only a write carries jamo codes
  `HGC_ASSERT_NOW(a_codes_none, m_axis_tvalid && m_axis_tuser != hgc_pkg::ACT_WRITE, m_axis_tdata[7:0] == hgc_pkg::NONE_CODE && m_axis_tdata[15:8] == hgc_pkg::NONE_CODE && m_axis_tdata[23:16] == hgc_pkg::NONE_CODE, "jamo codes on a non-write action")

endmodule

bind hangul_two_set_key_composer hgc_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef enum logic [2:0] {ST_PLAIN, ST_EMPTY, ST_LEAD, ST_VOWEL, ST_TAIL} cstate_t;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] lead;
    logic [7:0] vowel;
    logic [7:0] tail;
    logic [7:0] ch;
    logic       is_last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // key
  logic        s_axis_tuser = 1'b0;  // line_full
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;         // initial_code, medial_code, final_code, pass_char
  logic [2:0]  m_axis_tuser;         // action
  logic        m_axis_tlast;

  hangul_two_set_key_composer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // composer state as predicted
  logic [7:0] toggle_key;
  cstate_t    cst;
  logic [7:0] lead_j, vowel_j, tail_j, cons_key;
  logic [7:0] undo_mem [hgc_pkg::STACK_DEPTH];
  int         undo_sp;

  beat_t actions_due[$];
  beat_t want;
  int    key_beats;
  int    mismatches = 0;
  int    src_idle = 0;
  int    sink_stall = 0;
  string cons_keys = "rRseEfaqQtTdwWczxvgfrqst";
  string vowel_keys = "koiOjpuPhynbmlhnmkl";

  function automatic logic [7:0] lead_code(logic [7:0] k);
    case (k)
      "r": return 8'd129;  "R": return 8'd130;  "s": return 8'd131;
      "e": return 8'd132;  "E": return 8'd133;  "f": return 8'd134;
      "a": return 8'd135;  "q": return 8'd136;  "Q": return 8'd137;
      "t": return 8'd138;  "T": return 8'd139;  "d": return 8'd140;
      "w": return 8'd141;  "W": return 8'd142;  "c": return 8'd143;
      "z": return 8'd144;  "x": return 8'd145;  "v": return 8'd146;
      "g": return 8'd147;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] vowel_code(logic [7:0] k);
    case (k)
      "k": return 8'd129;  "o": return 8'd130;  "i": return 8'd131;
      "O": return 8'd132;  "j": return 8'd133;  "p": return 8'd134;
      "u": return 8'd135;  "P": return 8'd136;  "h": return 8'd137;
      "y": return 8'd141;  "n": return 8'd142;  "b": return 8'd146;
      "m": return 8'd147;  "l": return 8'd149;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] tail_code(logic [7:0] k);
    case (k)
      "r": return 8'd129;  "R": return 8'd130;  "s": return 8'd132;
      "e": return 8'd135;  "f": return 8'd136;  "a": return 8'd144;
      "q": return 8'd145;  "t": return 8'd147;  "T": return 8'd148;
      "d": return 8'd149;  "w": return 8'd150;  "c": return 8'd151;
      "z": return 8'd152;  "x": return 8'd153;  "v": return 8'd154;
      "g": return 8'd155;
      default: return 8'd0;
    endcase
  endfunction

  // compound finals
  function automatic logic [7:0] tail_pair(logic [7:0] t, logic [7:0] k);
    if (t == 8'd129 && k == "t") return 8'd131;
    if (t == 8'd132 && k == "w") return 8'd133;
    if (t == 8'd132 && k == "g") return 8'd134;
    if (t == 8'd136) begin
      case (k)
        "r": return 8'd137;  "a": return 8'd138;  "q": return 8'd139;
        "t": return 8'd140;  "x": return 8'd141;  "v": return 8'd142;
        "g": return 8'd143;
        default: return 8'd0;
      endcase
    end
    if (t == 8'd145 && k == "t") return 8'd146;
    return 8'd0;
  endfunction

  // compound vowels
  function automatic logic [7:0] vowel_pair(logic [7:0] v, logic [7:0] k);
    if (v == 8'd137 && k == "k") return 8'd138;
    if (v == 8'd137 && k == "o") return 8'd139;
    if (v == 8'd137 && k == "l") return 8'd140;
    if (v == 8'd142 && k == "j") return 8'd143;
    if (v == 8'd142 && k == "p") return 8'd144;
    if (v == 8'd142 && k == "l") return 8'd145;
    if (v == 8'd147 && k == "l") return 8'd148;
    return 8'd0;
  endfunction

  function automatic void note(logic [2:0] a, logic [7:0] l, logic [7:0] v,
                               logic [7:0] t, logic [7:0] c);
    actions_due.push_back('{a, l, v, t, c, 1'b0});
    key_beats++;
  endfunction

  function automatic void note_act(logic [2:0] a);
    note(a, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE, 8'd0);
  endfunction

  function automatic void note_syl(logic [7:0] l, logic [7:0] v, logic [7:0] t);
    note(hgc_pkg::ACT_WRITE, l, v, t, 8'd0);
  endfunction

  function automatic void push_undo(logic [7:0] v);
    if (undo_sp < hgc_pkg::STACK_DEPTH) begin
      undo_mem[undo_sp] = v;
      undo_sp++;
    end
  endfunction

  function automatic logic [7:0] pop_undo();
    if (undo_sp == 0) return hgc_pkg::NONE_CODE;
    undo_sp--;
    return undo_mem[undo_sp];
  endfunction

  function automatic void pass_along(logic [7:0] k);
    if (cst > ST_EMPTY && k != hgc_pkg::KEY_DEL) note_act(hgc_pkg::ACT_COMMIT);
    note(hgc_pkg::ACT_PASS, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE, k);
    if (cst != ST_PLAIN) cst = ST_EMPTY;
  endfunction

  function automatic void start_syllable(logic [7:0] l);
    note_act(hgc_pkg::ACT_COMMIT);
    note_act(hgc_pkg::ACT_OPEN);
    note_syl(l, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE);
    lead_j = l;
    undo_sp = 0;
    cst = ST_LEAD;
  endfunction

  function automatic void compose_key(logic [7:0] k, logic full);
    logic [7:0] lt, vt, ft, jv, jf, popped;
    beat_t b;
    lt = lead_code(k);
    vt = vowel_code(k);
    ft = tail_code(k);
    jv = vowel_pair(vowel_j, k);
    jf = tail_pair(tail_j, k);
    key_beats = 0;
    if (k == toggle_key) begin
      if (cst > ST_EMPTY) note_act(hgc_pkg::ACT_COMMIT);
      cst = (cst == ST_PLAIN) ? ST_EMPTY : ST_PLAIN;
    end else if (full && k != hgc_pkg::KEY_BS && k != hgc_pkg::KEY_CR &&
                 k != hgc_pkg::KEY_DEL) begin
      note_act(hgc_pkg::ACT_BELL);
    end else begin
      case (cst)
        ST_EMPTY: begin
          undo_sp = 0;
          if (lt != 0) begin
            note_act(hgc_pkg::ACT_OPEN);
            note_syl(lt, hgc_pkg::NONE_CODE, hgc_pkg::NONE_CODE);
            lead_j = lt;
            cst = ST_LEAD;
          end else if (vt != 0) begin
            note_act(hgc_pkg::ACT_OPEN);
            note_syl(hgc_pkg::NONE_CODE, vt, hgc_pkg::NONE_CODE);
            note_act(hgc_pkg::ACT_COMMIT);
          end else begin
            pass_along(k);
          end
        end
        ST_LEAD: begin
          if (vt != 0) begin
            note_syl(lead_j, vt, hgc_pkg::NONE_CODE);
            push_undo(hgc_pkg::NONE_CODE);
            vowel_j = vt;
            cst = ST_VOWEL;
          end else if (lt != 0) begin
            start_syllable(lt);
          end else if (k == hgc_pkg::KEY_BS) begin
            note_act(hgc_pkg::ACT_DELETE);
            cst = ST_EMPTY;
          end else begin
            pass_along(k);
          end
        end
        ST_VOWEL: begin
          if (ft != 0) begin
            note_syl(lead_j, vowel_j, ft);
            push_undo(hgc_pkg::NONE_CODE);
            tail_j = ft;
            cons_key = k;
            cst = ST_TAIL;
          end else if (jv != 0) begin
            note_syl(lead_j, jv, hgc_pkg::NONE_CODE);
            push_undo(vowel_j);
            vowel_j = jv;
          end else if (lt != 0) begin
            start_syllable(lt);
          end else if (vt != 0) begin
            note_act(hgc_pkg::ACT_COMMIT);
            note_act(hgc_pkg::ACT_OPEN);
            note_syl(hgc_pkg::NONE_CODE, vt, hgc_pkg::NONE_CODE);
            note_act(hgc_pkg::ACT_COMMIT);
            cst = ST_EMPTY;
          end else if (k == hgc_pkg::KEY_BS) begin
            vowel_j = pop_undo();
            note_syl(lead_j, vowel_j, hgc_pkg::NONE_CODE);
            if (vowel_j == hgc_pkg::NONE_CODE) cst = ST_LEAD;
          end else begin
            pass_along(k);
          end
        end
        ST_TAIL: begin
          if (jf != 0) begin
            note_syl(lead_j, vowel_j, jf);
            push_undo(tail_j);
            tail_j = jf;
            cons_key = k;
          end else if (vt != 0) begin
            // final consonant moves over to open the next syllable
            popped = pop_undo();
            note_syl(lead_j, vowel_j, popped);
            vowel_j = vt;
            lead_j = lead_code(cons_key);
            if (lead_j == 0) lead_j = hgc_pkg::NONE_CODE;
            note_act(hgc_pkg::ACT_COMMIT);
            note_act(hgc_pkg::ACT_OPEN);
            note_syl(lead_j, vowel_j, hgc_pkg::NONE_CODE);
            undo_sp = 0;
            push_undo(hgc_pkg::NONE_CODE);
            cst = ST_VOWEL;
          end else if (lt != 0) begin
            start_syllable(lt);
          end else if (k == hgc_pkg::KEY_BS) begin
            tail_j = pop_undo();
            note_syl(lead_j, vowel_j, tail_j);
            if (tail_j == hgc_pkg::NONE_CODE) cst = ST_VOWEL;
          end else begin
            pass_along(k);
          end
        end
        default: begin
          cst = ST_PLAIN;
          pass_along(k);
        end
      endcase
    end
    if (key_beats > 0) begin
      b = actions_due.pop_back();
      b.is_last = 1'b1;
      actions_due.push_back(b);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (actions_due.size() == 0) begin
        $display("%0t unexpected beat: expected none, got action %0d data %h last %b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = actions_due.pop_front();
        check_field("action", {5'd0, want.act}, {5'd0, m_axis_tuser});
        check_field("initial_code", want.lead, m_axis_tdata[7:0]);
        check_field("medial_code", want.vowel, m_axis_tdata[15:8]);
        check_field("final_code", want.tail, m_axis_tdata[23:16]);
        check_field("pass_char", want.ch, m_axis_tdata[31:24]);
        check_field("last", {7'd0, want.is_last}, {7'd0, m_axis_tlast});
      end
    end
  end

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall);

  task automatic send_key(input logic [7:0] k, input logic full);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = k;
    s_axis_tuser = full;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    compose_key(k, full);
  endtask

  task automatic type_keys(input string s);
    for (int i = 0; i < s.len(); i++) send_key(s[i], 1'b0);
  endtask

  // wait out every pending beat plus the key still in flight
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (actions_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_toggle(input logic [7:0] v);
    settle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    toggle_key = v;
  endtask

  function automatic logic [7:0] rand_key();
    int r;
    r = $urandom_range(99);
    if (cst == ST_PLAIN && r < 30) return toggle_key;
    if (r < 42) return cons_keys[$urandom_range(cons_keys.len() - 1)];
    if (r < 78) return vowel_keys[$urandom_range(vowel_keys.len() - 1)];
    if (r < 86) return hgc_pkg::KEY_BS;
    if (r < 88) return toggle_key;
    if (r < 92) return $urandom_range(1) ? hgc_pkg::KEY_CR : hgc_pkg::KEY_DEL;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_plain_mode();
    send_key("A", 1'b0);
    send_key(8'd255, 1'b0);
    send_key(hgc_pkg::KEY_BS, 1'b1);
    send_key(hgc_pkg::KEY_CR, 1'b0);
    send_key(hgc_pkg::KEY_DEL, 1'b1);
    send_key("x", 1'b1);
  endtask

  task automatic test_syllables();
    send_key(toggle_key, 1'b0);
    type_keys("rkskfr");
    send_key(hgc_pkg::KEY_BS, 1'b0);
    send_key(hgc_pkg::KEY_BS, 1'b0);
    type_keys("ldhlfrk");
    send_key(hgc_pkg::KEY_BS, 1'b0);
    send_key(hgc_pkg::KEY_BS, 1'b0);
    type_keys("krs");
    send_key("r", 1'b1);
    send_key(hgc_pkg::KEY_CR, 1'b0);
    send_key("g", 1'b0);
    send_key(toggle_key, 1'b0);
  endtask

  task automatic test_random_typing(input logic [7:0] tk, input int src_pct,
                                    input int sink_pct, input int count);
    set_toggle(tk);
    src_idle = src_pct;
    sink_stall = sink_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 49) settle();
      send_key(rand_key(), $urandom_range(99) < 5);
    end
  endtask

  initial begin
    toggle_key = 8'd0;
    cst = ST_PLAIN;
    lead_j = hgc_pkg::NONE_CODE;
    vowel_j = hgc_pkg::NONE_CODE;
    tail_j = hgc_pkg::NONE_CODE;
    cons_key = 8'd0;
    undo_sp = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_plain_mode();
    test_syllables();
    test_random_typing(8'd255, 0, 0, 125);
    test_random_typing("g", 59, 0, 125);
    test_random_typing(hgc_pkg::KEY_BS, 0, 59, 125);
    test_random_typing(8'd0, 38, 38, 125);
    settle();
    repeat (12) @(negedge clk);
    if (mismatches == 0 && actions_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
